// ===== src/hpt_pkg.sv =====
// Shared types and constants for the homogeneous point transform.
package hpt_pkg;

   // Q16.16 value width and fraction bits.
   localparam int unsigned QW = 32;
   localparam int unsigned QF = 16;
   localparam logic signed [QW-1:0] Q_ONE = 32'sh0001_0000;

   // Matrix register file.
   localparam int unsigned NUM_REGS = 8;
   localparam int unsigned REG_W    = 64;
   localparam int unsigned IDX_W    = 3;

   typedef logic [REG_W-1:0] reg_array_type [NUM_REGS];

   // Register reset values give the identity matrix.
   localparam reg_array_type REG_RESET = '{
      64'h0000_0000_0001_0000, 64'h0,
      64'h0001_0000_0000_0000, 64'h0,
      64'h0,                   64'h0000_0000_0001_0000,
      64'h0,                   64'h0001_0000_0000_0000
   };

   // Divider geometry: numerator is a Q16.16 value scaled by 2^16.
   localparam int unsigned DIV_NW    = QW + QF;
   localparam int unsigned DIV_STEPS = DIV_NW;
   localparam int unsigned ROW_LAT   = 3;
   localparam int unsigned DIV_LAT   = DIV_STEPS + 2;

   // Control that travels alongside each item.
   typedef struct packed {
      logic valid;
      logic dir;
      logic w_one;
      logic w_zero;
   } ctrl_type;

endpackage

// ===== src/homogeneous_point_transform.sv =====
// Top level: 4x4 homogeneous transform with perspective divide.
//
//  Channel   Ports                                      Direction
//  request   req_valid req_stall req_op req_in_x/y/z    in
//  response  rsp_valid rsp_stall rsp_out_x/y/z          out
//            rsp_zero_w_error
//  csr       csr_wr_en csr_index csr_wr_data            in
//
// One item enters per cycle while req_stall is low. Its result passes through
// three row-lane registers and fifty divider registers (the 48-step divider
// plus its input and output stages) into the output buffer.
// A two-entry output buffer holds results; input stalls only when it is full.
// Reset is synchronous and loads the identity matrix.
module homogeneous_point_transform (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_op,
   input  logic signed [hpt_pkg::QW-1:0]        req_in_x,
   input  logic signed [hpt_pkg::QW-1:0]        req_in_y,
   input  logic signed [hpt_pkg::QW-1:0]        req_in_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [hpt_pkg::QW-1:0]        rsp_out_x,
   output logic signed [hpt_pkg::QW-1:0]        rsp_out_y,
   output logic signed [hpt_pkg::QW-1:0]        rsp_out_z,
   output logic                                 rsp_zero_w_error,
   input  logic                                 csr_wr_en,
   input  logic [hpt_pkg::IDX_W-1:0]            csr_index,
   input  logic [hpt_pkg::REG_W-1:0]            csr_wr_data
);

   localparam int unsigned RL = hpt_pkg::ROW_LAT;
   localparam int unsigned DL = hpt_pkg::DIV_LAT;

   hpt_pkg::reg_array_type regs_ff;
   hpt_pkg::ctrl_type      ctrl_a_ff [RL];
   hpt_pkg::ctrl_type      ctrl_b_ff [DL];
   hpt_pkg::ctrl_type      ctrl_a_in;
   hpt_pkg::ctrl_type      ctrl_b_in;
   logic                   en;
   logic signed [31:0]     row_val [4];
   logic signed [31:0]     quot [3];
   logic signed [31:0]     pass [3];
   logic signed [31:0]     res [3];
   logic                   res_err;
   logic [1:0]             count_ff;
   logic [1:0]             count_in;
   logic                   push;
   logic                   pop;
   logic                   wr_pos;
   logic signed [31:0]     slot_xyz_ff [2][3];
   logic                   slot_err_ff [2];

   // Matrix register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= hpt_pkg::REG_RESET;
      end else if (csr_wr_en) begin
         regs_ff[csr_index] <= csr_wr_data;
      end
   end

   // The pipeline moves whenever the output buffer has room.
   assign en        = (count_ff != 2'd2);
   assign req_stall = !en;

   // Row lanes, one per matrix row.
   for (genvar r = 0; r < 4; r++) begin : g_row
      logic signed [31:0] coef [4];
      always_comb begin
         coef[0] = regs_ff[2*r][31:0];
         coef[1] = regs_ff[2*r][63:32];
         coef[2] = regs_ff[2*r+1][31:0];
         coef[3] = regs_ff[2*r+1][63:32];
      end
      hpt_row_lane u_row (
         .clock   (clock),
         .en      (en),
         .coef    (coef),
         .vec_x   (req_in_x),
         .vec_y   (req_in_y),
         .vec_z   (req_in_z),
         .dir     (req_op),
         .row_out (row_val[r])
      );
   end

   // Divider lanes for x, y and z against w.
   for (genvar d = 0; d < 3; d++) begin : g_div
      hpt_div_lane u_div (
         .clock    (clock),
         .en       (en),
         .num_in   (row_val[d]),
         .den_in   (row_val[3]),
         .quot_out (quot[d]),
         .pass_out (pass[d])
      );
   end

   // Control pipelines beside the row lanes and the dividers.
   always_comb begin
      ctrl_a_in        = '0;
      ctrl_a_in.valid  = req_valid;
      ctrl_a_in.dir    = req_op;
      ctrl_b_in        = ctrl_a_ff[RL-1];
      ctrl_b_in.w_one  = (row_val[3] == hpt_pkg::Q_ONE);
      ctrl_b_in.w_zero = (row_val[3] == 32'sd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RL; i++) ctrl_a_ff[i] <= '0;
         for (int i = 0; i < DL; i++) ctrl_b_ff[i] <= '0;
      end else if (en) begin
         ctrl_a_ff[0] <= ctrl_a_in;
         for (int i = 1; i < RL; i++) ctrl_a_ff[i] <= ctrl_a_ff[i-1];
         ctrl_b_ff[0] <= ctrl_b_in;
         for (int i = 1; i < DL; i++) ctrl_b_ff[i] <= ctrl_b_ff[i-1];
      end
   end

   // Merge: pick the plain sum, zero or the quotient.
   always_comb begin
      res_err = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (ctrl_b_ff[DL-1].dir || ctrl_b_ff[DL-1].w_one) begin
            res[i] = pass[i];
         end else if (ctrl_b_ff[DL-1].w_zero) begin
            res[i] = 32'sd0;
         end else begin
            res[i] = quot[i];
         end
      end
      if (!ctrl_b_ff[DL-1].dir && ctrl_b_ff[DL-1].w_zero) begin
         res_err = 1'b1;
      end
   end

   // Two-entry output buffer.
   always_comb begin
      push     = en && ctrl_b_ff[DL-1].valid;
      pop      = (count_ff != 2'd0) && !rsp_stall;
      wr_pos   = (count_ff == 2'd2) || ((count_ff == 2'd1) && !pop);
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   // A new item lands in the head slot when the head is free or leaving;
   // otherwise the head takes the second slot on a pop.
   always_ff @(posedge clock) begin
      if (push && !wr_pos) begin
         slot_xyz_ff[0] <= res;
         slot_err_ff[0] <= res_err;
      end else if (pop) begin
         slot_xyz_ff[0] <= slot_xyz_ff[1];
         slot_err_ff[0] <= slot_err_ff[1];
      end
      if (push && wr_pos) begin
         slot_xyz_ff[1] <= res;
         slot_err_ff[1] <= res_err;
      end
   end

   assign rsp_valid        = (count_ff != 2'd0);
   assign rsp_out_x        = slot_xyz_ff[0][0];
   assign rsp_out_y        = slot_xyz_ff[0][1];
   assign rsp_out_z        = slot_xyz_ff[0][2];
   assign rsp_zero_w_error = slot_err_ff[0];

endmodule

// ===== src/hpt_row_lane.sv =====
// One matrix row dot product with floor scaling and 32-bit saturation.
module hpt_row_lane (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [hpt_pkg::QW-1:0]      coef [4],
   input  logic signed [hpt_pkg::QW-1:0]      vec_x,
   input  logic signed [hpt_pkg::QW-1:0]      vec_y,
   input  logic signed [hpt_pkg::QW-1:0]      vec_z,
   input  logic                               dir,
   output logic signed [hpt_pkg::QW-1:0]      row_out
);

   logic signed [63:0] prod_ff [4];
   logic signed [63:0] prod_in [4];
   logic signed [64:0] pair_ff [2];
   logic signed [65:0] total;
   logic signed [49:0] scaled;
   logic signed [hpt_pkg::QW-1:0] row_ff;
   logic signed [hpt_pkg::QW-1:0] row_in;

   // Products; the fourth component is 1.0 for a point and 0 for a direction.
   always_comb begin
      prod_in[0] = 64'(coef[0]) * 64'(vec_x);
      prod_in[1] = 64'(coef[1]) * 64'(vec_y);
      prod_in[2] = 64'(coef[2]) * 64'(vec_z);
      prod_in[3] = dir ? 64'sd0 : (64'(coef[3]) <<< hpt_pkg::QF);
   end

   // Final sum, floor divide by 2^16 and saturate.
   always_comb begin
      total  = 66'(pair_ff[0]) + 66'(pair_ff[1]);
      scaled = 50'(total >>> hpt_pkg::QF);
      if (scaled > 50'sh7FFF_FFFF) begin
         row_in = 32'sh7FFF_FFFF;
      end else if (scaled < -50'sh8000_0000) begin
         row_in = 32'sh8000_0000;
      end else begin
         row_in = scaled[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff    <= prod_in;
         pair_ff[0] <= 65'(prod_ff[0]) + 65'(prod_ff[1]);
         pair_ff[1] <= 65'(prod_ff[2]) + 65'(prod_ff[3]);
         row_ff     <= row_in;
      end
   end

   assign row_out = row_ff;

endmodule

// ===== src/hpt_div_lane.sv =====
// Pipelined signed restoring divider, one quotient bit per stage.
module hpt_div_lane (
   input  logic                           clock,
   input  logic                           en,
   input  logic signed [hpt_pkg::QW-1:0]  num_in,
   input  logic signed [hpt_pkg::QW-1:0]  den_in,
   output logic signed [hpt_pkg::QW-1:0]  quot_out,
   output logic signed [hpt_pkg::QW-1:0]  pass_out
);

   localparam int unsigned NW = hpt_pkg::DIV_NW;
   localparam int unsigned NS = hpt_pkg::DIV_STEPS;

   logic [31:0]   rem_ff  [NS+1];
   logic [NW-1:0] dq_ff   [NS+1];
   logic [31:0]   den_ff  [NS+1];
   logic          neg_ff  [NS+1];
   logic signed [31:0] pass_ff [NS+1];
   logic [31:0]   rem_in  [NS];
   logic [NW-1:0] dq_in   [NS];
   logic [31:0]   num_mag;
   logic [31:0]   den_mag;
   logic [NW-1:0] qmag;
   logic signed [31:0] quot_ff;
   logic signed [31:0] quot_in;
   logic signed [31:0] pass_o_ff;

   // Operand magnitudes and result sign.
   always_comb begin
      num_mag = num_in[31] ? 32'(-num_in) : 32'(num_in);
      den_mag = den_in[31] ? 32'(-den_in) : 32'(den_in);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= '0;
         dq_ff[0]   <= {num_mag, {hpt_pkg::QF{1'b0}}};
         den_ff[0]  <= den_mag;
         neg_ff[0]  <= num_in[31] ^ den_in[31];
         pass_ff[0] <= num_in;
      end
   end

   // Restoring steps; quotient bits shift into the dividend register.
   for (genvar k = 0; k < NS; k++) begin : g_step
      logic [32:0] shifted;
      logic [32:0] diff;
      always_comb begin
         shifted = {rem_ff[k], dq_ff[k][NW-1]};
         diff    = shifted - {1'b0, den_ff[k]};
         if (shifted >= {1'b0, den_ff[k]}) begin
            rem_in[k] = diff[31:0];
            dq_in[k]  = {dq_ff[k][NW-2:0], 1'b1};
         end else begin
            rem_in[k] = shifted[31:0];
            dq_in[k]  = {dq_ff[k][NW-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= rem_in[k];
            dq_ff[k+1]   <= dq_in[k];
            den_ff[k+1]  <= den_ff[k];
            neg_ff[k+1]  <= neg_ff[k];
            pass_ff[k+1] <= pass_ff[k];
         end
      end
   end

   // Apply the sign and saturate to 32 bits.
   always_comb begin
      qmag = dq_ff[NS];
      if (neg_ff[NS]) begin
         if (qmag > NW'(33'h0_8000_0000)) begin
            quot_in = 32'sh8000_0000;
         end else begin
            quot_in = 32'(~qmag + NW'(1));
         end
      end else if (qmag > NW'(33'h0_7FFF_FFFF)) begin
         quot_in = 32'sh7FFF_FFFF;
      end else begin
         quot_in = qmag[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quot_ff   <= quot_in;
         pass_o_ff <= pass_ff[NS];
      end
   end

   assign quot_out = quot_ff;
   assign pass_out = pass_o_ff;

endmodule
